// ----- design/gse_pkg.sv -----
// Shared types and constants for the Gaussian/Sobel edge stream block.
// Used by every module of the block but gse_chk; depends on nothing.
package gse_pkg;

	localparam int CFG_ADDR_BITS = 4;
	localparam int COUNT_LIMIT = 1024;
	localparam logic [15:0] BLUR_RECIP = 16'd52759;
	localparam int BLUR_SHIFT = 23;
	localparam logic [13:0] MAG_SCALE_NUM = 14'd10000;
	localparam logic [18:0] MAG_SCALE_DEN = 19'd320356;

	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam logic [10:0] RST_IMAGE_WIDTH = 11'd640;
	localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [7:0] RST_EDGE_THRESHOLD = 8'd5;

	localparam logic [3:0] GAUSS_W [5][5] = '{
		'{4'd2, 4'd4, 4'd5, 4'd4, 4'd2},
		'{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
		'{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
		'{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
		'{4'd2, 4'd4, 4'd5, 4'd4, 4'd2}
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_ACC,
		ST_DIV,
		ST_BW,
		ST_SOB,
		ST_MAG,
		ST_OUT
	} gse_st_t;

	typedef enum logic [2:0] {
		MP_IDLE,
		MP_SQX,
		MP_SQY,
		MP_LIM,
		MP_SQC,
		MP_CMP
	} gse_mph_t;

	typedef struct packed {
		logic rd;
		logic win;
		logic acc;
		logic [2:0] acc_row;
		logic div;
		logic bw;
	} gse_ctl_t;

endpackage

// ----- design/gse_blur.sv -----
// Raw line memory, 5x5 raw window and Gaussian sum with divide by 159.
// Depends on gse_pkg; sequenced by the control in the top level.
module gse_blur #(
	parameter int MAX_LINE = 1024
) (
	input logic clk,
	input logic arst_n,
	input gse_pkg::gse_ctl_t ctl,
	input logic [$clog2(MAX_LINE)-1:0] rd_addr,
	input logic [7:0] pix,
	output logic [7:0] blur
);
	import gse_pkg::*;

	localparam int AW = $clog2(MAX_LINE);

	logic [31:0] mem [MAX_LINE];
	logic [31:0] rd_q;
	logic [AW-1:0] addr_q;
	logic [7:0] pix_q;
	logic [7:0] win_q [5][5];
	logic [15:0] acc_q;
	logic [7:0] blur_q;
	logic [7:0] col [5];
	logic [13:0] row_sum;

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q <= mem[rd_addr];
			addr_q <= rd_addr;
			pix_q <= pix;
		end
		if (ctl.win) begin
			mem[addr_q] <= {pix_q, rd_q[31:8]};
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			col[k] = rd_q[8*k +: 8];
		end
		col[4] = pix_q;
		row_sum = '0;
		for (int c = 0; c < 5; c++) begin
			row_sum = row_sum
				+ 14'(GAUSS_W[ctl.acc_row][c]) * 14'(win_q[ctl.acc_row][c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 5; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (ctl.win) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][4] <= col[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			acc_q <= ((ctl.acc_row == 3'd0) ? 16'd0 : acc_q) + 16'(row_sum);
		end
		if (ctl.div) begin
			blur_q <= 8'((32'(acc_q) * 32'(BLUR_RECIP)) >> BLUR_SHIFT);
		end
	end

	assign blur = blur_q;

endmodule

// ----- design/gse_sobel.sv -----
// Blurred line memory, 3x3 blurred window and Sobel gradients.
// Depends on gse_pkg; sequenced by the control in the top level.
module gse_sobel #(
	parameter int MAX_LINE = 1024
) (
	input logic clk,
	input logic arst_n,
	input gse_pkg::gse_ctl_t ctl,
	input logic [$clog2(MAX_LINE)-1:0] rd_addr,
	input logic [7:0] blur,
	output logic signed [10:0] gx,
	output logic signed [10:0] gy
);
	import gse_pkg::*;

	localparam int AW = $clog2(MAX_LINE);

	logic [15:0] mem [MAX_LINE];
	logic [15:0] rd_q;
	logic [AW-1:0] addr_q;
	logic [7:0] win_q [9];
	logic signed [10:0] b [9];

	always_ff @(posedge clk) begin
		if (ctl.win) begin
			rd_q <= mem[rd_addr];
			addr_q <= rd_addr;
		end
		if (ctl.bw) begin
			mem[addr_q] <= {blur, rd_q[15:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (ctl.bw) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3] <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= rd_q[7:0];
			win_q[5] <= rd_q[15:8];
			win_q[8] <= blur;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			b[i] = signed'({3'b000, win_q[i]});
		end
		gx = (b[2] + 11'sd2 * b[5] + b[8]) - (b[0] + 11'sd2 * b[3] + b[6]);
		gy = (b[6] + 11'sd2 * b[7] + b[8]) - (b[0] + 11'sd2 * b[1] + b[2]);
	end

endmodule

// ----- design/gse_mag.sv -----
// Bit-serial scaled gradient magnitude: largest r with 320356 r^2 <= 10000 (gx^2 + gy^2).
// Depends on gse_pkg; one multiplier pass per cycle.
module gse_mag (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [10:0] gx,
	input logic signed [10:0] gy,
	output logic done,
	output logic [7:0] mag
);
	import gse_pkg::*;

	gse_mph_t ph_q, ph_d;
	logic signed [10:0] gx_q, gy_q;
	logic [20:0] sq_q;
	logic [20:0] s_q;
	logic [35:0] lim_q;
	logic [15:0] cs_q;
	logic [7:0] bit_q;
	logic [7:0] r_q;
	logic signed [21:0] prod;
	logic [7:0] cand;

	assign cand = r_q | bit_q;
	assign prod = (ph_q == MP_SQX) ? gx_q * gx_q : gy_q * gy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= MP_IDLE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_comb begin
		ph_d = ph_q;
		done = 1'b0;
		unique case (ph_q)
			MP_IDLE: if (start) ph_d = MP_SQX;
			MP_SQX: ph_d = MP_SQY;
			MP_SQY: ph_d = MP_LIM;
			MP_LIM: ph_d = MP_SQC;
			MP_SQC: ph_d = MP_CMP;
			MP_CMP: begin
				if (bit_q[0]) begin
					ph_d = MP_IDLE;
					done = 1'b1;
				end else begin
					ph_d = MP_SQC;
				end
			end
			default: ph_d = MP_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			MP_IDLE: begin
				if (start) begin
					gx_q <= gx;
					gy_q <= gy;
					bit_q <= 8'h80;
					r_q <= '0;
				end
			end
			MP_SQX: sq_q <= prod[20:0];
			MP_SQY: s_q <= sq_q + prod[20:0];
			MP_LIM: lim_q <= 36'(s_q) * 36'(MAG_SCALE_NUM);
			MP_SQC: cs_q <= 16'(cand) * 16'(cand);
			MP_CMP: begin
				if (36'(cs_q) * 36'(MAG_SCALE_DEN) <= lim_q) begin
					r_q <= cand;
				end
				bit_q <= bit_q >> 1;
			end
			default: ;
		endcase
	end

	assign mag = r_q;

endmodule

// ----- design/gaussian_sobel_edge_stream.sv -----
// Top level of the Gaussian 5x5 blur, Sobel 3x3 and gradient magnitude stream.
// Depends on gse_pkg, gse_blur, gse_sobel and gse_mag.
//
// Pixels enter one request at a time in raster order and are handled one after another.
// A pixel that yields no blurred value only updates the raw line memory and window;
// one that yields a blurred value also sums, divides and writes the blurred line; one that
// yields a result also waits on the bit-serial magnitude unit, one trial per result bit.
// A finished result sits in the output register, so the next pixel is taken while it
// waits. The line memories have no reset; results appear only for pixels whose 7x7
// neighborhood lies inside the frame, three lines and three columns behind the input.
module gaussian_sobel_edge_stream #(
	parameter int MAX_LINE = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [gse_pkg::CFG_ADDR_BITS-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] pixel_level,
	input logic frame_start,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] grad_level,
	output logic is_edge,
	output logic [9:0] out_col,
	output logic [9:0] out_row
);
	import gse_pkg::*;

	localparam int AW = $clog2(MAX_LINE);
	localparam int LINE_LIM = (MAX_LINE < COUNT_LIMIT) ? MAX_LINE : COUNT_LIMIT;

	logic [10:0] width_q, height_q;
	logic [7:0] thr_q;
	logic [9:0] col_q, row_q, x_s1, y_s1;
	gse_st_t st_q, st_d;
	logic [2:0] acc_q;
	gse_ctl_t ctl;
	logic in_acc;
	logic [9:0] base_col, base_row;
	logic [10:0] line_len, frame_len;
	logic [31:0] raw_addr32, blur_addr32;
	logic [7:0] blur;
	logic signed [10:0] gx, gy;
	logic mag_start, mag_done;
	logic [7:0] mag;
	logic out_load;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			thr_q <= RST_EDGE_THRESHOLD;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH: width_q <= pwdata[10:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[10:0];
				REG_EDGE_THRESHOLD: thr_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH: prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			REG_EDGE_THRESHOLD: prdata = 32'(thr_q);
			default: prdata = '0;
		endcase
	end

	assign in_acc = in_valid & in_ready;
	assign base_col = frame_start ? 10'd0 : col_q;
	assign base_row = frame_start ? 10'd0 : row_q;
	assign line_len = (width_q > 11'(LINE_LIM)) ? 11'(LINE_LIM) : width_q;
	assign frame_len = (height_q > 11'(COUNT_LIMIT)) ? 11'(COUNT_LIMIT) : height_q;
	assign raw_addr32 = 32'(base_col);
	assign blur_addr32 = 32'(x_s1 - 10'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (11'(base_col) + 11'd1 >= line_len) begin
				col_q <= '0;
				row_q <= (11'(base_row) + 11'd1 >= frame_len) ? 10'd0 : base_row + 10'd1;
			end else begin
				col_q <= base_col + 10'd1;
				row_q <= base_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1 <= base_col;
			y_s1 <= base_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			acc_q <= '0;
		end else begin
			st_q <= st_d;
			acc_q <= (st_q == ST_ACC) ? acc_q + 3'd1 : 3'd0;
		end
	end

	always_comb begin
		st_d = st_q;
		ctl = '0;
		ctl.acc_row = acc_q;
		in_ready = 1'b0;
		mag_start = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.rd = in_valid;
				if (in_valid) st_d = ST_WIN;
			end
			ST_WIN: begin
				ctl.win = 1'b1;
				st_d = (x_s1 >= 10'd4 && y_s1 >= 10'd4) ? ST_ACC : ST_IDLE;
			end
			ST_ACC: begin
				ctl.acc = 1'b1;
				if (acc_q == 3'd4) st_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				st_d = ST_BW;
			end
			ST_BW: begin
				ctl.bw = 1'b1;
				st_d = (x_s1 >= 10'd6 && y_s1 >= 10'd6) ? ST_SOB : ST_IDLE;
			end
			ST_SOB: begin
				mag_start = 1'b1;
				st_d = ST_MAG;
			end
			ST_MAG: begin
				if (mag_done) st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	gse_blur #(.MAX_LINE(MAX_LINE)) u_blur (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rd_addr(raw_addr32[AW-1:0]),
		.pix(pixel_level),
		.blur(blur)
	);

	gse_sobel #(.MAX_LINE(MAX_LINE)) u_sobel (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rd_addr(blur_addr32[AW-1:0]),
		.blur(blur),
		.gx(gx),
		.gy(gy)
	);

	gse_mag u_mag (
		.clk(clk),
		.arst_n(arst_n),
		.start(mag_start),
		.gx(gx),
		.gy(gy),
		.done(mag_done),
		.mag(mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			grad_level <= mag;
			is_edge <= (mag >= thr_q);
			out_col <= x_s1 - 10'd3;
			out_row <= y_s1 - 10'd3;
		end
	end

endmodule

// ----- design/gse_chk.sv -----
// Port-level checks for the edge stream top level, bound to every instance.
// Depends only on the top level's ports.
module gse_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] grad_level,
	input logic [9:0] out_col,
	input logic [9:0] out_row
);

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second request was taken while one is in work.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(grad_level) && $stable(out_col))
		else $error("A waiting result changed or vanished.");

	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_col >= 10'd3 && out_row >= 10'd3)
		else $error("A result was given for a border pixel.");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> grad_level != 8'hFF)
		else $error("Gradient magnitude out of range.");

endmodule

bind gaussian_sobel_edge_stream gse_chk u_gse_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.grad_level(grad_level),
	.out_col(out_col),
	.out_row(out_row)
);

// ----- tb/gaussian_sobel_edge_stream_test.sv -----
// Testbench for gaussian_sobel_edge_stream: drives pixel requests and register writes,
// predicts blur, Sobel and gradient magnitude per pixel and checks every result in order.
// Depends on gse_pkg and the gaussian_sobel_edge_stream RTL.
`timescale 1ns / 1ps

module gaussian_sobel_edge_stream_test;
	import gse_pkg::*;

	typedef struct {
		logic [7:0] grad;
		logic edge_flag;
		logic [9:0] col;
		logic [9:0] row;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] pixel_level = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] grad_level;
	logic is_edge;
	logic [9:0] out_col;
	logic [9:0] out_row;

	gaussian_sobel_edge_stream dut (.*);

	always #5 clk = ~clk;

	edge_result_t expected_results[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	logic [7:0] raw_rows [4][1024];
	logic [7:0] blur_rows [2][1024];
	logic [7:0] raw_win [25];
	logic [7:0] blur_win [9];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [10:0] width_reg = RST_IMAGE_WIDTH;
	logic [10:0] height_reg = RST_IMAGE_HEIGHT;
	logic [7:0] threshold_reg = RST_EDGE_THRESHOLD;

	localparam int GW [5][5] = '{
		'{2, 4, 5, 4, 2},
		'{4, 9, 12, 9, 4},
		'{5, 12, 15, 12, 5},
		'{4, 9, 12, 9, 4},
		'{2, 4, 5, 4, 2}
	};

	function automatic logic [7:0] scaled_magnitude(input int gx, input int gy);
		longint unsigned lim;
		longint unsigned cand;
		logic [7:0] r;
		lim = longint'(gx * gx + gy * gy) * 10000;
		r = 0;
		for (int b = 7; b >= 0; b--) begin
			cand = r | (8'd1 << b);
			if (cand * cand * 320356 <= lim) r[b] = 1'b1;
		end
		return r;
	endfunction

	function automatic void predict_pixel(input logic [7:0] pix, input logic fs);
		int unsigned x, y, bx, sum, llen, flen;
		logic [7:0] colv [5];
		logic [7:0] blur, b0, b1;
		int gx, gy;
		edge_result_t res;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		x = col_pos;
		y = row_pos;
		if (x >= 1024) x = 1023;
		for (int k = 0; k < 4; k++) colv[k] = raw_rows[k][x];
		colv[4] = pix;
		for (int k = 0; k < 4; k++) raw_rows[k][x] = colv[k + 1];
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 4; c++) raw_win[r * 5 + c] = raw_win[r * 5 + c + 1];
			raw_win[r * 5 + 4] = colv[r];
		end
		if (x >= 4 && y >= 4) begin
			sum = 0;
			bx = x - 2;
			for (int r = 0; r < 5; r++)
				for (int c = 0; c < 5; c++) sum += GW[r][c] * raw_win[r * 5 + c];
			blur = 8'(sum / 159);
			b0 = blur_rows[0][bx];
			b1 = blur_rows[1][bx];
			blur_rows[0][bx] = b1;
			blur_rows[1][bx] = blur;
			for (int r = 0; r < 3; r++) begin
				blur_win[r * 3] = blur_win[r * 3 + 1];
				blur_win[r * 3 + 1] = blur_win[r * 3 + 2];
			end
			blur_win[2] = b0;
			blur_win[5] = b1;
			blur_win[8] = blur;
			if (x >= 6 && y >= 6) begin
				gx = (int'(blur_win[2]) + 2 * int'(blur_win[5]) + int'(blur_win[8]))
					- (int'(blur_win[0]) + 2 * int'(blur_win[3]) + int'(blur_win[6]));
				gy = (int'(blur_win[6]) + 2 * int'(blur_win[7]) + int'(blur_win[8]))
					- (int'(blur_win[0]) + 2 * int'(blur_win[1]) + int'(blur_win[2]));
				res.grad = scaled_magnitude(gx, gy);
				res.edge_flag = res.grad >= threshold_reg;
				res.col = 10'(x - 3);
				res.row = 10'(y - 3);
				expected_results.push_back(res);
			end
		end
		llen = (width_reg > 1024) ? 1024 : width_reg;
		flen = (height_reg > 1024) ? 1024 : height_reg;
		if (col_pos + 1 >= llen) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= flen) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result grad=%0d edge=%0d col=%0d row=%0d",
						grad_level, is_edge, out_col, out_row);
			end else begin
				edge_result_t e;
				e = expected_results.pop_front();
				if (grad_level !== e.grad || is_edge !== e.edge_flag ||
						out_col !== e.col || out_row !== e.row) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Result mismatch: expected grad=%0d edge=%0d col=%0d",
							" row=%0d, got grad=%0d edge=%0d col=%0d row=%0d"},
							e.grad, e.edge_flag, e.col, e.row,
							grad_level, is_edge, out_col, out_row);
				end
			end
		end
	end

	task automatic send_pixel(input logic [7:0] pix, input logic fs);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel_level <= pix;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		predict_pixel(pix, fs);
	endtask

	task automatic drain_pipeline();
		@(posedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'(index) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_IMAGE_WIDTH: width_reg = value[10:0];
			REG_IMAGE_HEIGHT: height_reg = value[10:0];
			REG_EDGE_THRESHOLD: threshold_reg = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_frame_size(input int w, input int h, input int thr);
		drain_pipeline();
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		write_register(REG_EDGE_THRESHOLD, thr);
	endtask

	// Each frame is a ramp, a hard step or noise, so the magnitude covers a wide range.
	task automatic send_frame(input int w, input int h, input bit noisy);
		int style, base;
		logic [7:0] pix;
		style = $urandom_range(3);
		base = $urandom_range(255);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				case (style)
					0: pix = 8'(base + x * $urandom_range(40) + y * 3);
					1: pix = ((x + y) > w / 2) ? 8'hFF : 8'h00;
					2: pix = (y > h / 2) ? 8'(base) : 8'(~base);
					default: pix = 8'($urandom());
				endcase
				if (noisy) pix = pix ^ 8'($urandom_range(15));
				send_pixel(pix, x == 0 && y == 0);
			end
	endtask

	task automatic test_directed_extremes();
		set_frame_size(7, 7, 0);
		for (int i = 0; i < 49; i++) send_pixel((i % 7) < 3 ? 8'h00 : 8'hFF, i == 0);
		set_frame_size(7, 7, 255);
		for (int i = 0; i < 49; i++) send_pixel((i / 7) < 3 ? 8'hFF : 8'h00, i == 0);
	endtask

	task automatic test_register_extremes();
		set_frame_size(2047, 1024, 3);
		for (int i = 0; i < 1026; i++) send_pixel(8'($urandom()), i == 0);
		set_frame_size(3, 0, 255);
		for (int i = 0; i < 12; i++) send_pixel(8'($urandom()), i == 0);
		set_frame_size(1, 2, 255);
		for (int i = 0; i < 6; i++) send_pixel(8'($urandom()), i == 0);
		set_frame_size(8, 7, 'hFFFF_FF10);
		send_frame(8, 7, 0);
		send_frame(8, 7, 1);
	endtask

	task automatic test_random_frames(input int sidle, input int rstall, input int items);
		int w, h, sent, col;
		set_frame_size($urandom_range(7, 14), $urandom_range(7, 10), $urandom_range(255));
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		sent = 0;
		while (sent < items) begin
			w = width_reg;
			h = height_reg;
			if ($urandom_range(9) == 0) begin
				col = $urandom_range(w * 3);
				send_pixel(8'($urandom()), 1'b1);
				for (int i = 0; i < col; i++) send_pixel(8'($urandom()), 1'b0);
				sent += col + 1;
			end else begin
				send_frame(w, h, $urandom_range(1));
				sent += w * h;
			end
		end
		drain_pipeline();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_register_extremes();
		test_random_frames(0, 0, 130);
		test_random_frames(79, 0, 130);
		test_random_frames(0, 79, 130);
		test_random_frames(26, 26, 130);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
